@@ rtl/iowa_pkg.sv @@
// Shared types and constants for the IPv4 per-octet wildcard permit-list unit.
// Depends on nothing; every other file of the block imports it.
package iowa_pkg;

	localparam int unsigned RULES_PER_LIST_DEF = 16;
	localparam int unsigned NUM_LISTS          = 2;

	// Command codes carried in the command field of an input beat.
	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_CHECK = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic        list_select;
		logic [31:0] address;
		logic [3:0]  wildcard_mask;
	} acl_item_t;

	typedef struct packed {
		logic       allowed;
		logic [3:0] matched_rule;
		logic       status;
	} acl_result_t;

	// One stored rule: the pattern and its per-octet wildcard bits.
	typedef struct packed {
		logic [31:0] octets;
		logic [3:0]  wildcards;
	} rule_t;

endpackage

@@ rtl/ipv4_octet_wildcard_acl_unit.sv @@
// Top level of the IPv4 per-octet wildcard permit-list unit.
// Depends on iowa_pkg, iowa_rule_mem, iowa_match and iowa_seq.
//
// Usage. The block keeps two permit lists, connect (list 0) and bind (list 1),
// each with up to RULES_PER_LIST rules. A command beat is taken at a rising
// edge where start is high and busy is low; it adds a rule, checks an address
// or clears both lists. Every beat gives exactly one result beat, shown on
// result for one cycle while done is high. The receiver cannot hold it off.
//
// Timing. Add, clear, an unused code and a check of an empty list answer in
// the cycle after the command beat; busy stays low, so a new beat may follow
// at once. A check walks the selected list one rule per cycle through the
// rule memory, whose read port is registered, and the one compare unit. It
// stops at the first hit. busy is high while the scan runs and low again
// with the result beat. The rule count sets the length of the walk, to which
// the registered read and the result register add.
//
// Reset. arst_n clears both rule counts and the sequencer; the rule memory
// itself is not cleared, since entries are read only after they are written.
module ipv4_octet_wildcard_acl_unit #(
	parameter int unsigned RULES_PER_LIST = iowa_pkg::RULES_PER_LIST_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  iowa_pkg::acl_item_t   item,
	output logic                  busy,
	output logic                  done,
	output iowa_pkg::acl_result_t result
);
	import iowa_pkg::*;

	localparam int unsigned DEPTH  = NUM_LISTS * RULES_PER_LIST;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	rule_t             wr_rule;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	rule_t             rd_rule;
	logic [31:0]       scan_address;
	logic              hit;

	// The sequencer owns the counts and the scan index; during a scan it issues
	// one read a cycle and judges the rule that its previous read returned.
	iowa_seq #(
		.RULES_PER_LIST(RULES_PER_LIST)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.done         (done),
		.result       (result),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_rule      (wr_rule),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.scan_address (scan_address),
		.hit          (hit)
	);

	// List 0 occupies the lower half of the memory, list 1 the upper half.
	iowa_rule_mem #(
		.RULES_PER_LIST(RULES_PER_LIST)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_rule (wr_rule),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_rule (rd_rule)
	);

	// Octets are compared as numbers; a wildcard octet always matches.
	iowa_match u_match (
		.rule    (rd_rule),
		.address (scan_address),
		.hit     (hit)
	);

endmodule

@@ rtl/iowa_rule_mem.sv @@
// Rule storage for both permit lists: one write port, one registered read port.
// Depends on iowa_pkg for the rule entry type.
module iowa_rule_mem #(
	parameter int unsigned RULES_PER_LIST = iowa_pkg::RULES_PER_LIST_DEF,
	localparam int unsigned DEPTH  = iowa_pkg::NUM_LISTS * RULES_PER_LIST,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  iowa_pkg::rule_t     wr_rule,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output iowa_pkg::rule_t     rd_rule
);
	import iowa_pkg::*;

	rule_t mem_q [DEPTH];
	rule_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_rule;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_rule = rd_q;

endmodule

@@ rtl/iowa_match.sv @@
// Shared compare unit: matches one stored rule against the address under test.
// Depends on iowa_pkg for the rule entry type.
module iowa_match (
	input  iowa_pkg::rule_t rule,
	input  logic [31:0]     address,
	output logic            hit
);
	import iowa_pkg::*;

	logic [3:0] octet_ok;

	// Bit 3 of the wildcard mask belongs to the first octet, bits 31:24.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			octet_ok[3-k] = rule.wildcards[3-k] ||
				(rule.octets[31-8*k -: 8] == address[31-8*k -: 8]);
		end
	end

	assign hit = &octet_ok;

endmodule

@@ rtl/iowa_seq.sv @@
// Sequencer: takes command beats, keeps the rule counts, walks a list one rule
// per cycle through the rule memory and the compare unit. Depends on iowa_pkg.
module iowa_seq #(
	parameter int unsigned RULES_PER_LIST = iowa_pkg::RULES_PER_LIST_DEF,
	localparam int unsigned DEPTH  = iowa_pkg::NUM_LISTS * RULES_PER_LIST,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  iowa_pkg::acl_item_t   item,
	output logic                  busy,
	output logic                  done,
	output iowa_pkg::acl_result_t result,
	output logic                  wr_en,
	output logic [ADDR_W-1:0]     wr_addr,
	output iowa_pkg::rule_t       wr_rule,
	output logic                  rd_en,
	output logic [ADDR_W-1:0]     rd_addr,
	output logic [31:0]           scan_address,
	input  logic                  hit
);
	import iowa_pkg::*;

	localparam int unsigned CNT_W = $clog2(RULES_PER_LIST + 1);
	localparam int unsigned IDX_W = (RULES_PER_LIST > 1) ? $clog2(RULES_PER_LIST) : 1;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q [NUM_LISTS];
	acl_item_t           item_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                cmp_vld_q;
	logic [IDX_W-1:0]    cmp_idx_q;
	logic                done_q;
	acl_result_t         result_q;

	logic                accept;
	logic                issue;
	logic                scan_end;
	logic                room;
	logic                go_scan;
	logic [CNT_W-1:0]    sel_count;
	logic [CNT_W-1:0]    scan_count;
	acl_result_t         imm_result;

	assign accept     = start && (state_q == ST_IDLE);
	assign sel_count  = count_q[item.list_select];
	assign scan_count = count_q[item_q.list_select];
	assign room       = sel_count < CNT_W'(RULES_PER_LIST);
	assign go_scan    = (item.command == CMD_CHECK) && (sel_count != '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && go_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and datapath control.
	always_comb begin
		busy     = 1'b0;
		issue    = 1'b0;
		scan_end = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_SCAN: begin
				busy     = 1'b1;
				issue    = scan_idx_q < scan_count;
				scan_end = cmp_vld_q && (hit || !issue);
			end
			default: busy = 1'b0;
		endcase
	end

	assign rd_en   = issue;
	assign rd_addr = item_q.list_select
		? ADDR_W'(RULES_PER_LIST) + ADDR_W'(scan_idx_q[IDX_W-1:0])
		: ADDR_W'(scan_idx_q[IDX_W-1:0]);

	assign wr_en   = accept && (item.command == CMD_ADD) && room;
	assign wr_addr = item.list_select
		? ADDR_W'(RULES_PER_LIST) + ADDR_W'(sel_count[IDX_W-1:0])
		: ADDR_W'(sel_count[IDX_W-1:0]);
	assign wr_rule = '{octets: item.address, wildcards: item.wildcard_mask};

	assign scan_address = item_q.address;

	// Results that need no scan are known at the accepting edge.
	always_comb begin
		imm_result = '0;
		case (item.command)
			CMD_ADD: imm_result.status = !room;
			default: imm_result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '{default: '0};
			scan_idx_q <= '0;
			cmp_vld_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && !go_scan) || scan_end;
			if (accept) begin
				scan_idx_q <= '0;
				case (item.command)
					CMD_ADD: begin
						if (room) begin
							count_q[item.list_select] <= sel_count + CNT_W'(1);
						end
					end
					CMD_CLEAR: count_q <= '{default: '0};
					default: ;
				endcase
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			cmp_vld_q <= (state_q == ST_SCAN) && !scan_end && issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= item;
			result_q <= imm_result;
		end else if (scan_end) begin
			result_q.allowed      <= hit;
			result_q.matched_rule <= hit ? 4'(cmp_idx_q) : 4'd0;
			result_q.status       <= 1'b0;
		end
		cmp_idx_q <= scan_idx_q[IDX_W-1:0];
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe while a scan is still running");

	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_q |-> state_q == ST_SCAN)
		else $error("compare pending outside a scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] <= CNT_W'(RULES_PER_LIST)) && (count_q[1] <= CNT_W'(RULES_PER_LIST)))
		else $error("rule count beyond list size");

	a_allow_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.allowed |-> !result_q.status)
		else $error("allowed check reports a dropped add");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		scan_end |=> done_q && !busy)
		else $error("scan finished without a result beat");

endmodule
